// File: sv/kwm_pkg.sv
// kwm_pkg: shared types and codes of the k-way doclist merge core
// no dependencies
`default_nettype none
package kwm_pkg;

	localparam int unsigned LIST_COUNT_DEF = 16;
	localparam int unsigned LIST_DEPTH_DEF = 1024;

	localparam int unsigned ID_W    = 64;
	localparam int unsigned STATE_W = 8;
	localparam int unsigned ENTRY_W = ID_W + STATE_W;
	localparam int unsigned KEEP_W  = 32;
	localparam int unsigned DEL_W   = 24;

	localparam logic [KEEP_W-1:0] KEEP_RESET   = 32'hFFFF_FFFF;
	localparam logic [DEL_W-1:0]  DEL_RESET    = 24'd10000000;
	localparam logic [DEL_W-1:0]  DEL_SAT      = 24'hFF_FFFF;
	localparam logic [STATE_W-1:0] DELCODE_RESET = 8'd1;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_PULL   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_REJECT   = 3'd1,
		STS_ENTRY    = 3'd2,
		STS_FINISHED = 3'd3,
		STS_DELSTOP  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_PURGE   = 2'd0,
		CFG_MAXKEEP = 2'd1,
		CFG_DELLIM  = 2'd2,
		CFG_DELCODE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_CONS,
		ST_RDW,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// File: sv/kway_doclist_merge_dedup_core.sv
// kway_doclist_merge_dedup_core: k-way merge of descending doc id lists with dedup
// depends on kwm_pkg and kwm_store
//
// An append, clear or rejected request goes from idle straight to the emit state. A pull
// runs a shared 64-bit compare unit over the cached list heads, one list a cycle, then
// walks the lists once more to consume every entry with the winning id; each consumed
// entry that has another entry behind it in its list costs one entry memory read and a
// read-wait state. A pull that skips purged entries repeats the search for each of
// them. The result then leaves through an output register; the input is not ready until
// the request has finished.
`default_nettype none
module kway_doclist_merge_dedup_core #(
	parameter int unsigned LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
	parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,  // doc_id[63:0], doc_state[71:64]
	input  wire  [5:0]  s_tuser,  // req_type[1:0], list_index[5:2]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,  // out_doc_id[63:0], out_doc_state[71:64]
	output logic [2:0]  m_tuser,  // status[2:0]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import kwm_pkg::*;

	localparam int unsigned LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int unsigned HW    = $clog2(LIST_DEPTH + 1);
	localparam int unsigned MDEP  = LIST_COUNT * LIST_DEPTH;
	localparam int unsigned AW    = $clog2(MDEP);
	localparam logic [LW-1:0] LAST_L = LW'(LIST_COUNT - 1);

	state_t state_q, state_d;

	logic                purge_q;
	logic [KEEP_W-1:0]   maxkeep_q;
	logic [DEL_W-1:0]    dellim_q;
	logic [STATE_W-1:0]  delcode_q;

	logic [HW-1:0]       fill_q [LIST_COUNT];
	logic [HW-1:0]       head_q [LIST_COUNT];
	logic [ID_W-1:0]     cid_q  [LIST_COUNT];
	logic [STATE_W-1:0]  cst_q  [LIST_COUNT];
	logic [LIST_COUNT-1:0] cval_q;

	logic [KEEP_W-1:0]   live_q;
	logic [DEL_W-1:0]    delcnt_q;
	logic                running_q, finished_q;

	logic [LW-1:0]       l_q;
	logic [ID_W-1:0]     best_q;
	logic [LW-1:0]       win_q;
	logic                give_q;
	logic [STATE_W-1:0]  gst_q;

	logic [2:0]          rsts_q;
	logic [ID_W-1:0]     rid_q;
	logic [STATE_W-1:0]  rst_q;

	logic                m_tvalid_q;
	logic [71:0]         m_tdata_q;
	logic [2:0]          m_tuser_q;

	logic [1:0]          req;
	logic [3:0]          li_in;
	logic [LW-1:0]       li;
	logic                li_ok;
	logic [ID_W-1:0]     id_in;
	logic [STATE_W-1:0]  st_in;
	logic                in_acc;

	logic [ID_W-1:0]     hid;
	logic [HW-1:0]       hnext;
	logic                we, re;
	logic [AW-1:0]       waddr, raddr;
	logic [ENTRY_W-1:0]  rdata;
	logic                slot_free;
	logic [2:0]          fin_code;

	assign req    = s_tuser[1:0];
	assign li_in  = s_tuser[5:2];
	assign li     = LW'(li_in);
	assign li_ok  = 32'(li_in) < LIST_COUNT;
	assign id_in  = s_tdata[63:0];
	assign st_in  = s_tdata[71:64];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign slot_free = !m_tvalid_q || m_tready;

	assign hid   = cval_q[l_q] ? cid_q[l_q] : '0;
	assign hnext = head_q[l_q] + HW'(1);
	assign fin_code = (delcnt_q > dellim_q) ? STS_DELSTOP : STS_FINISHED;

	assign we    = in_acc && (req == REQ_APPEND) && li_ok && !running_q && !finished_q
		&& (fill_q[li] < HW'(LIST_DEPTH));
	assign waddr = AW'(li) * AW'(LIST_DEPTH) + AW'(fill_q[li]);
	assign re    = (state_q == ST_CONS) && (hid == best_q) && (hnext < fill_q[l_q]);
	assign raddr = AW'(l_q) * AW'(LIST_DEPTH) + AW'(hnext);

	kwm_store #(.DEPTH(MDEP), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({st_in, id_in}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req == REQ_PULL && !finished_q) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (l_q == LAST_L) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (best_q == '0) ? ST_EMIT : ST_CONS;
			end
			ST_CONS: begin
				if (hid == best_q) begin
					if (re) begin
						state_d = ST_RDW;
					end
				end else if (l_q == LAST_L) begin
					state_d = give_q ? ST_EMIT : ST_SCAN;
				end
			end
			ST_RDW: begin
				state_d = ST_CONS;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purge_q   <= 1'b1;
			maxkeep_q <= KEEP_RESET;
			dellim_q  <= DEL_RESET;
			delcode_q <= DELCODE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PURGE:   purge_q   <= cfg_data[0];
				CFG_MAXKEEP: maxkeep_q <= cfg_data;
				CFG_DELLIM:  dellim_q  <= cfg_data[DEL_W-1:0];
				CFG_DELCODE: delcode_q <= cfg_data[STATE_W-1:0];
				default:     purge_q   <= purge_q;
			endcase
		end
	end

	// list bookkeeping, merge control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_COUNT; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
			cval_q     <= '0;
			live_q     <= '0;
			delcnt_q   <= '0;
			running_q  <= 1'b0;
			finished_q <= 1'b0;
			l_q        <= '0;
			give_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					l_q <= '0;
					if (in_acc && req == REQ_CLEAR) begin
						for (int i = 0; i < LIST_COUNT; i++) begin
							fill_q[i] <= '0;
							head_q[i] <= '0;
						end
						cval_q     <= '0;
						live_q     <= '0;
						delcnt_q   <= '0;
						running_q  <= 1'b0;
						finished_q <= 1'b0;
					end else if (we) begin
						fill_q[li] <= fill_q[li] + HW'(1);
						if (fill_q[li] == head_q[li]) begin
							cval_q[li] <= 1'b1;
						end
					end else if (in_acc && req == REQ_PULL && !finished_q) begin
						running_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					l_q <= l_q + LW'(1);
				end
				ST_DECIDE: begin
					l_q <= '0;
					give_q <= 1'b0;
					if (best_q == '0) begin
						finished_q <= 1'b1;
						running_q  <= 1'b0;
					end else if (purge_q) begin
						if (cst_q[win_q] != delcode_q) begin
							give_q <= 1'b1;
							live_q <= live_q + KEEP_W'(1);
							if ((live_q + KEEP_W'(1)) >= maxkeep_q) begin
								finished_q <= 1'b1;
							end
						end
					end else if (cst_q[win_q] != delcode_q) begin
						if (live_q < maxkeep_q) begin
							give_q <= 1'b1;
							live_q <= live_q + KEEP_W'(1);
						end
					end else begin
						give_q <= 1'b1;
						if (delcnt_q != DEL_SAT) begin
							delcnt_q <= delcnt_q + DEL_W'(1);
							if ((delcnt_q + DEL_W'(1)) > dellim_q) begin
								finished_q <= 1'b1;
							end
						end else if (delcnt_q > dellim_q) begin
							finished_q <= 1'b1;
						end
					end
				end
				ST_CONS: begin
					if (hid == best_q) begin
						head_q[l_q] <= hnext;
						if (!re) begin
							cval_q[l_q] <= 1'b0;
						end
					end else begin
						if (l_q == LAST_L) begin
							l_q <= '0;
							if (give_q && finished_q) begin
								running_q <= 1'b0;
							end
						end else begin
							l_q <= l_q + LW'(1);
						end
					end
				end
				default: begin
					l_q <= l_q;
				end
			endcase
		end
	end

	// head cache, search and result payload
	always_ff @(posedge clk) begin
		if (we && fill_q[li] == head_q[li]) begin
			cid_q[li] <= id_in;
			cst_q[li] <= st_in;
		end
		if (state_q == ST_RDW) begin
			cid_q[l_q] <= rdata[ID_W-1:0];
			cst_q[l_q] <= rdata[ENTRY_W-1:ID_W];
		end
		case (state_q)
			ST_IDLE: begin
				best_q <= '0;
				win_q  <= '0;
				rid_q  <= '0;
				rst_q  <= '0;
				if (req == REQ_PULL) begin
					rsts_q <= fin_code;
				end else if (req == REQ_CLEAR || we) begin
					rsts_q <= STS_OK;
				end else begin
					rsts_q <= STS_REJECT;
				end
			end
			ST_SCAN: begin
				if (hid != '0 && hid >= best_q) begin
					best_q <= hid;
					win_q  <= l_q;
				end
			end
			ST_DECIDE: begin
				gst_q  <= cst_q[win_q];
				rsts_q <= fin_code;
			end
			ST_CONS: begin
				if (hid != best_q && l_q == LAST_L) begin
					if (give_q) begin
						rsts_q <= STS_ENTRY;
						rid_q  <= best_q;
						rst_q  <= gst_q;
					end
					best_q <= '0;
					win_q  <= '0;
				end
			end
			default: begin
				rid_q <= rid_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			m_tdata_q <= {rst_q, rid_q};
			m_tuser_q <= rsts_q;
		end
	end

	a_run_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(running_q && finished_q))
		else $error("merge running and finished together");

	a_cons_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONS) |-> (best_q != '0))
		else $error("consume pass without a winning id");

	a_rdw_from_cons: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDW) |-> ($past(state_q) == ST_CONS))
		else $error("read wait not entered from consume pass");

	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready straight after a transaction");

endmodule
`default_nettype wire

// File: sv/kwm_store.sv
// kwm_store: entry memory of all lists, one write and one registered read port
// depends on kwm_pkg
`default_nettype none
module kwm_store #(
	parameter int unsigned DEPTH = 16384,
	parameter int unsigned AW    = 14
) (
	input  wire                         clk,
	input  wire                         we,
	input  wire  [AW-1:0]               waddr,
	input  wire  [kwm_pkg::ENTRY_W-1:0] wdata,
	input  wire                         re,
	input  wire  [AW-1:0]               raddr,
	output logic [kwm_pkg::ENTRY_W-1:0] rdata
);
	import kwm_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking testbench for kway_doclist_merge_dedup_core
// drives append, pull and clear transactions and checks every result against a merge predictor
// depends on kwm_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none

class merge_scoreboard;
	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] doc_id;
		logic [7:0]  doc_state;
	} merge_result_t;

	bit [63:0] ent_id [16][1024];
	bit [7:0]  ent_state [16][1024];
	int unsigned fill [16];
	int unsigned head [16];
	bit [31:0] live_cnt;
	bit [23:0] del_cnt;
	bit running, finished;
	bit purge = 1;
	bit [31:0] max_keep = kwm_pkg::KEEP_RESET;
	bit [23:0] del_limit = kwm_pkg::DEL_RESET;
	bit [7:0]  del_code = kwm_pkg::DELCODE_RESET;
	merge_result_t pending [$];
	int errors;
	int results_seen;

	function void clear_all();
		for (int l = 0; l < 16; l++) begin
			fill[l] = 0;
			head[l] = 0;
		end
		live_cnt = 0;
		del_cnt = 0;
		running = 0;
		finished = 0;
	endfunction

	function void set_reg(kwm_pkg::cfg_idx_t idx, bit [31:0] v);
		case (idx)
			kwm_pkg::CFG_PURGE: purge = v[0];
			kwm_pkg::CFG_MAXKEEP: max_keep = v;
			kwm_pkg::CFG_DELLIM: del_limit = v[23:0];
			default: del_code = v[7:0];
		endcase
	endfunction

	function bit [63:0] head_of(int l);
		if (head[l] >= fill[l]) return 0;
		return ent_id[l][head[l]];
	endfunction

	function bit [2:0] finish_status();
		return (del_cnt > del_limit) ? kwm_pkg::STS_DELSTOP : kwm_pkg::STS_FINISHED;
	endfunction

	function merge_result_t merge_next();
		merge_result_t r;
		bit [63:0] best;
		int win;
		bit [7:0] st;
		bit give;
		r = '0;
		if (finished) begin
			r.status = finish_status();
			return r;
		end
		running = 1;
		forever begin
			best = 0;
			win = 0;
			give = 0;
			for (int l = 0; l < 16; l++)
				if (head_of(l) != 0 && head_of(l) >= best) begin
					best = head_of(l);
					win = l;
				end
			if (best == 0) begin
				finished = 1;
				running = 0;
				r.status = finish_status();
				return r;
			end
			st = ent_state[win][head[win]];
			if (purge) begin
				if (st != del_code) begin
					give = 1;
					live_cnt++;
					if (live_cnt >= max_keep) finished = 1;
				end
			end else if (st != del_code) begin
				if (live_cnt < max_keep) begin
					give = 1;
					live_cnt++;
				end
			end else begin
				give = 1;
				if (del_cnt != kwm_pkg::DEL_SAT) del_cnt++;
				if (del_cnt > del_limit) finished = 1;
			end
			for (int l = 0; l < 16; l++)
				while (head_of(l) == best && best != 0) head[l]++;
			if (give) begin
				if (finished) running = 0;
				r.status = kwm_pkg::STS_ENTRY;
				r.doc_id = best;
				r.doc_state = st;
				return r;
			end
		end
	endfunction

	function void note_request(bit [1:0] req, bit [3:0] li, bit [63:0] id, bit [7:0] st);
		merge_result_t r;
		r = '0;
		r.status = kwm_pkg::STS_REJECT;
		case (req)
			kwm_pkg::REQ_APPEND:
				if (!running && !finished && fill[li] < 1024) begin
					ent_id[li][fill[li]] = id;
					ent_state[li][fill[li]] = st;
					fill[li]++;
					r.status = kwm_pkg::STS_OK;
				end
			kwm_pkg::REQ_CLEAR: begin
				clear_all();
				r.status = kwm_pkg::STS_OK;
			end
			kwm_pkg::REQ_PULL: r = merge_next();
			default: ;
		endcase
		pending = {pending, r};
	endfunction

	task report(string what, logic [71:0] got, logic [71:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	task check_result(logic [2:0] status, logic [63:0] id, logic [7:0] st);
		merge_result_t e;
		results_seen++;
		if (pending.size() == 0) begin
			report("unexpected result", {id, st}, '0);
			return;
		end
		e = pending.pop_front();
		if (status !== e.status) report("status", status, e.status);
		if (id !== e.doc_id) report("doc id", id, e.doc_id);
		if (st !== e.doc_state) report("doc state", st, e.doc_state);
	endtask
endclass

module tb_top;
	import kwm_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic [5:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [71:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	merge_scoreboard sb = new();
	int unsigned cycles;
	int unsigned hold;
	int pulls_given;
	bit stall_free;
	localparam int unsigned LIMIT = 3000000;

	always #5 clk = ~clk;

	kway_doclist_merge_dedup_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function int unsigned gap_len();
		if (stall_free) return 0;
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver with random back-pressure, mostly short and now and then long
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (m_tuser == STS_ENTRY) pulls_given++;
				sb.check_result(m_tuser, m_tdata[63:0], m_tdata[71:64]);
			end
			if (stall_free) begin
				m_tready <= 1'b1;
			end else if (hold != 0) begin
				hold <= hold - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 39) == 0) begin
				hold <= $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task send(bit [1:0] req, bit [3:0] li, bit [63:0] id, bit [7:0] st);
		repeat (gap_len() + 1) @(posedge clk);
		s_tvalid <= 1;
		s_tuser <= {li, req};
		s_tdata <= {st, id};
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, li, id, st);
		s_tvalid <= 0;
	endtask

	task write_reg(cfg_idx_t idx, bit [31:0] v);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
		cfg_valid <= 0;
	endtask

	// load lists with descending random ids, overlapping on purpose
	task load_lists(int n_per, bit [7:0] code);
		bit [63:0] id;
		for (int l = 0; l < 16; l++) begin
			if ($urandom_range(0, 3) == 0) continue;
			id = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : 64'd200;
			for (int k = 0; k < n_per; k++) begin
				send(REQ_APPEND, 4'(l), id,
					($urandom_range(0, 2) == 0) ? code : 8'($urandom));
				id = (id > 3) ? id - 64'($urandom_range(1, 3)) : 0;
			end
		end
	endtask

	initial begin
		bit [31:0] keep;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part: extremes, all request kinds, rejects
		send(REQ_APPEND, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send(REQ_APPEND, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
		send(REQ_APPEND, 4'd3, 64'd5, 8'd1);
		send(REQ_APPEND, 4'd3, 64'd0, 8'd7);
		send(REQ_APPEND, 4'd3, 64'd4, 8'd7);
		send(REQ_APPEND, 4'd7, 64'd5, 8'd9);
		send(REQ_NONE, 4'd9, 64'h1234, 8'h56);
		repeat (5) send(REQ_PULL, 4'd0, 0, 0);
		send(REQ_APPEND, 4'd1, 64'd9, 8'd0);
		send(REQ_CLEAR, 4'd0, 0, 0);
		for (int k = 0; k < 1024; k++) begin
			stall_free = 1;
			send(REQ_APPEND, 4'd2, 64'd2000 - k, k[7:0]);
		end
		send(REQ_APPEND, 4'd2, 64'd1, 8'd0);
		stall_free = 0;
		repeat (3) send(REQ_PULL, 4'd5, 0, 0);
		send(REQ_CLEAR, 4'd0, 0, 0);

		// configuration phases, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_PURGE, 32'(ph[1]));
			case (ph % 4)
				0: keep = 32'hFFFF_FFFF;
				1: keep = 1;
				2: keep = 0;
				default: keep = $urandom_range(2, 12);
			endcase
			write_reg(CFG_MAXKEEP, keep);
			write_reg(CFG_DELLIM, 32'((ph % 5 == 0) ? 24'hFF_FFFF :
				(ph % 5 == 1) ? 24'd0 : 24'($urandom_range(1, 6))));
			write_reg(CFG_DELCODE, 32'((ph == 3) ? 8'hFF : (ph == 4) ? 8'h00 :
				8'($urandom)));
			send(REQ_CLEAR, 4'd0, 0, 0);
			load_lists($urandom_range(1, 2), sb.del_code);
			for (int k = 0; k < 6; k++)
				send(REQ_PULL, 4'($urandom), {$urandom, $urandom}, 8'($urandom));
			if ($urandom_range(0, 1))
				send(REQ_APPEND, 4'($urandom), {$urandom, $urandom}, 8'($urandom));
			if ($urandom_range(0, 3) == 0) send(REQ_NONE, 4'($urandom), 0, 0);
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("merge phases run with %0d results checked, %0d merged entries given",
			sb.results_seen, pulls_given);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
